[hw/rtl/i2ctrf_pkg.sv]
package i2ctrf_pkg;

    // register store geometry
    localparam int REG_COUNT = 256;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 8;

    // data-ready counter
    localparam int                CNT_W       = 18;
    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  DELAY_RESET = 18'd200000;

    // apb register addresses
    localparam logic [2:0]        ADDR_READY_DELAY = 3'd0;

    // special pointer values
    localparam logic [ADDR_W-1:0] PTR_READY_CLEAR = 8'h80;
    localparam logic [ADDR_W-1:0] PTR_REMAP_FROM  = 8'h81;
    localparam logic [ADDR_W-1:0] PTR_REMAP_TO    = 8'h82;

    // write port of the register store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } store_wr_t;

    // contents of the store after reset: identity bytes, zero elsewhere
    function automatic logic [DATA_W-1:0] init_value(input logic [ADDR_W-1:0] addr);
        logic [DATA_W-1:0] val;
        case (addr)
            8'h00:   val = 8'h03;
            8'h1F:   val = 8'h05;
            8'h7F:   val = 8'h01;
            8'h80:   val = 8'h23;
            8'h81:   val = 8'h45;
            8'h82:   val = 8'h67;
            8'h83:   val = 8'h89;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/i2ctrf_regstore.sv]
module i2ctrf_regstore
    import i2ctrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_wr_t         wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0]    store_mem [REG_COUNT];
    logic [DATA_W-1:0]    mem_q_reg;
    logic [REG_COUNT-1:0] valid_reg;
    logic                 valid_q_reg;
    logic                 fwd_reg;
    logic [DATA_W-1:0]    fwd_data_reg;
    logic [ADDR_W-1:0]    addr_q_reg;

    // synchronous memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        mem_q_reg    <= store_mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    // valid bits, forwarding flag and registered read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            addr_q_reg  <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[rd_addr];
            fwd_reg     <= wr.en && (wr.addr == rd_addr);
            addr_q_reg  <= rd_addr;
        end
    end

    // same-address write wins, unwritten entries read their reset byte
    always_comb
    begin
        if (fwd_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (valid_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = init_value(addr_q_reg);
        end
    end

endmodule

[hw/rtl/i2c_target_register_file.sv]
// I2C target with a 256-byte register file, stepped on sampled bus lines.
// Input stream (s_axis): one word per tick of sampled SCL/SDA levels plus
// update flags that choose whether each line's latched level is refreshed.
// Output stream (m_axis): one word per input word with the SDA drive
// enable, the driven SDA level and the data-ready pin, after the step.
// Configuration: APB register at address 0 holds the data-ready delay in
// ticks (18 bits, 200000 after reset).
// Throughput: one word per cycle while the skid stage is empty. The register
// bytes sit in a 256x8 synchronous memory read ahead at the next pointer
// value, with forwarding of a write to the same byte; that read bounds the step.
// Output: a result is registered before it appears on m_axis.
// When m_axis stalls, one more result is held in a skid stage and
// s_axis_tready drops only once that stage is full.
// Reset: the state machine waits for an idle bus, the lines read high, the
// counter and data-ready clear, and every byte reads its reset value at
// once (per-byte valid bits), so words are accepted right after reset.
module i2c_target_register_file
    import i2ctrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // scl_level, scl_update, sda_level, sda_update
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // sda_drive_enable, sda_out, data_ready
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_START      = 5'd1;
    localparam logic [4:0] S_ADDR       = 5'd2;
    localparam logic [4:0] S_ACK_RISE   = 5'd3;
    localparam logic [4:0] S_ACK_FALL   = 5'd4;
    localparam logic [4:0] S_PTR        = 5'd5;
    localparam logic [4:0] S_D1_RISE    = 5'd6;
    localparam logic [4:0] S_D1_LOW     = 5'd7;
    localparam logic [4:0] S_DATA_IN    = 5'd8;
    localparam logic [4:0] S_STOP_RISE  = 5'd9;
    localparam logic [4:0] S_STOP_HIGH  = 5'd10;
    localparam logic [4:0] S_TX_BIT     = 5'd11;
    localparam logic [4:0] S_TX_END     = 5'd12;
    localparam logic [4:0] S_MACK       = 5'd13;
    localparam logic [4:0] S_MNACK_FALL = 5'd14;
    localparam logic [4:0] S_MACK_FALL  = 5'd15;

    logic [CNT_W-1:0]  delay_reg;
    logic [4:0]        fsm_state_reg, fsm_state_next;
    logic [4:0]        ret_reg, ret_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;
    logic [DATA_W-1:0] shift_reg, shift_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              rw_reg, rw_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              scl_prev_reg;
    logic              sda_prev_reg;
    logic              drv_en_reg, drv_en_next;
    logic              drv_val_reg, drv_val_next;
    logic              rdy_reg, rdy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg;
    logic [2:0]        out_data_reg;
    logic              skid_valid_reg;
    logic [2:0]        skid_data_reg;

    logic              accept;
    logic              rise;
    logic              fall;
    logic              rdy_clear;
    logic [3:0]        bit_inc;
    logic [DATA_W-1:0] shift_in;
    logic [ADDR_W-1:0] ptr_byte;
    logic [CNT_W-1:0]  cnt_base;
    logic [2:0]        result;
    logic [DATA_W-1:0] rd_data;
    store_wr_t         store_wr;

    // apb register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_READY_DELAY))
        begin
            delay_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr == ADDR_READY_DELAY)
        begin
            prdata = {{(32-CNT_W){1'b0}}, delay_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // handshake
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // line latching and edge detection
    assign scl_next = s_axis_tdata[1] ? s_axis_tdata[0] : scl_reg;
    assign sda_next = s_axis_tdata[3] ? s_axis_tdata[2] : sda_reg;
    assign rise     = !scl_prev_reg && scl_next;
    assign fall     = scl_prev_reg && !scl_next;
    assign bit_inc  = bit_cnt_reg + 4'd1;
    assign shift_in = {shift_reg[DATA_W-2:0], sda_next};
    assign ptr_byte = (shift_in == PTR_REMAP_FROM) ? PTR_REMAP_TO : shift_in;

    // bus state machine
    always_comb
    begin
        fsm_state_next = fsm_state_reg;
        ret_next       = ret_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        ptr_next       = ptr_reg;
        rw_next        = rw_reg;
        drv_en_next    = drv_en_reg;
        drv_val_next   = drv_val_reg;
        rdy_clear      = 1'b0;
        store_wr       = '{en: 1'b0, addr: ptr_reg, data: shift_in};
        case (fsm_state_reg)
            S_IDLE:
            begin
                if (scl_next && sda_next)
                begin
                    fsm_state_next = S_START;
                end
            end
            S_START:
            begin
                if (scl_next && !sda_next)
                begin
                    fsm_state_next = ret_reg;
                end
                else if (!scl_next)
                begin
                    fsm_state_next = S_IDLE;
                end
            end
            S_ADDR:
            begin
                if (rise)
                begin
                    shift_next   = shift_in;
                    bit_cnt_next = bit_inc;
                    if (bit_inc == 4'd8)
                    begin
                        rw_next        = shift_in[0];
                        shift_next     = '0;
                        bit_cnt_next   = '0;
                        ret_next       = shift_in[0] ? S_TX_BIT : S_PTR;
                        fsm_state_next = S_ACK_RISE;
                    end
                end
            end
            S_ACK_RISE:
            begin
                if (rise)
                begin
                    drv_en_next    = 1'b1;
                    drv_val_next   = 1'b0;
                    fsm_state_next = S_ACK_FALL;
                end
            end
            S_ACK_FALL:
            begin
                if (fall)
                begin
                    drv_en_next    = 1'b0;
                    drv_val_next   = 1'b1;
                    fsm_state_next = ret_reg;
                end
            end
            S_PTR:
            begin
                if (rise)
                begin
                    shift_next   = shift_in;
                    bit_cnt_next = bit_inc;
                    if (bit_inc == 4'd8)
                    begin
                        rdy_clear      = (ptr_byte == PTR_READY_CLEAR);
                        ptr_next       = ptr_byte;
                        shift_next     = '0;
                        bit_cnt_next   = '0;
                        ret_next       = S_D1_RISE;
                        fsm_state_next = S_ACK_RISE;
                    end
                end
            end
            S_D1_RISE:
            begin
                if (rise)
                begin
                    fsm_state_next = S_D1_LOW;
                end
            end
            S_D1_LOW:
            begin
                if (!scl_next)
                begin
                    shift_next     = shift_reg | {{(DATA_W-1){1'b0}}, sda_prev_reg};
                    bit_cnt_next   = 4'd1;
                    fsm_state_next = S_DATA_IN;
                end
                else if (!sda_next && sda_prev_reg)
                begin
                    ret_next       = S_ADDR;
                    fsm_state_next = S_START;
                end
            end
            S_DATA_IN:
            begin
                if (rise)
                begin
                    shift_next   = shift_in;
                    bit_cnt_next = bit_inc;
                    if (bit_inc == 4'd8)
                    begin
                        store_wr.en    = accept;
                        shift_next     = '0;
                        bit_cnt_next   = '0;
                        ret_next       = S_STOP_RISE;
                        fsm_state_next = S_ACK_RISE;
                    end
                end
            end
            S_STOP_RISE:
            begin
                if (rise && !sda_next)
                begin
                    fsm_state_next = S_STOP_HIGH;
                end
            end
            S_STOP_HIGH:
            begin
                if (scl_next && sda_next)
                begin
                    ret_next       = S_ADDR;
                    fsm_state_next = S_IDLE;
                end
            end
            S_TX_BIT:
            begin
                if (rise)
                begin
                    drv_en_next  = 1'b1;
                    drv_val_next = rd_data[~bit_cnt_reg[2:0]];
                    bit_cnt_next = bit_inc;
                    if (bit_inc == 4'd8)
                    begin
                        shift_next     = '0;
                        bit_cnt_next   = '0;
                        fsm_state_next = S_TX_END;
                    end
                end
            end
            S_TX_END:
            begin
                if (fall)
                begin
                    drv_en_next    = 1'b0;
                    drv_val_next   = 1'b1;
                    fsm_state_next = S_MACK;
                end
            end
            S_MACK:
            begin
                if (rise)
                begin
                    if (sda_next)
                    begin
                        fsm_state_next = S_MNACK_FALL;
                    end
                    else
                    begin
                        ptr_next       = ptr_reg + 8'd1;
                        fsm_state_next = S_MACK_FALL;
                    end
                end
            end
            S_MNACK_FALL:
            begin
                if (fall)
                begin
                    ret_next       = S_ADDR;
                    fsm_state_next = S_STOP_RISE;
                end
            end
            S_MACK_FALL:
            begin
                if (fall)
                begin
                    fsm_state_next = S_TX_BIT;
                end
            end
            default:
            begin
                fsm_state_next = S_IDLE;
            end
        endcase
    end

    // saturating data-ready counter
    always_comb
    begin
        cnt_base = rdy_clear ? '0 : cnt_reg;
        cnt_next = (cnt_base != CNT_MAX) ? cnt_base + 18'd1 : cnt_base;
        rdy_next = (cnt_next == delay_reg) ? 1'b1 : (rdy_reg && !rdy_clear);
    end

    assign result = {rdy_next, drv_en_next && drv_val_next, drv_en_next};

    // register store, read ahead at the next pointer
    i2ctrf_regstore u_regstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (store_wr),
        .rd_addr (accept ? ptr_next : ptr_reg),
        .rd_data (rd_data)
    );

    // state registers, stepped once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_state_reg <= S_IDLE;
            ret_reg       <= S_ADDR;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            ptr_reg       <= '0;
            rw_reg        <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            scl_prev_reg  <= 1'b1;
            sda_prev_reg  <= 1'b1;
            drv_en_reg    <= 1'b0;
            drv_val_reg   <= 1'b0;
            rdy_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (accept)
        begin
            fsm_state_reg <= fsm_state_next;
            ret_reg       <= ret_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            ptr_reg       <= ptr_next;
            rw_reg        <= rw_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            scl_prev_reg  <= scl_next;
            sda_prev_reg  <= sda_next;
            drv_en_reg    <= drv_en_next;
            drv_val_reg   <= drv_val_next;
            rdy_reg       <= rdy_next;
            cnt_reg       <= cnt_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

endmodule

[dv/i2c_target_register_file_checker.sv]
`timescale 1ns / 1ps

module i2c_target_register_file_checker
    import i2ctrf_pkg::*;
#(
    parameter logic [2:0] DELAY_ADDR = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // scl_level, scl_update, sda_level, sda_update
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // sda_drive_enable, sda_out, data_ready
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    typedef enum logic [4:0] {
        ST_WAIT_IDLE,
        ST_WAIT_START,
        ST_ADDRESS,
        ST_ACK_RISE,
        ST_ACK_FALL,
        ST_POINTER,
        ST_FIRST_RISE,
        ST_FIRST_LOW,
        ST_DATA_IN,
        ST_STOP_RISE,
        ST_STOP_HIGH,
        ST_SEND_BIT,
        ST_SEND_END,
        ST_HOST_ACK,
        ST_HOST_NACK_FALL,
        ST_HOST_ACK_FALL
    } target_state_t;

    // pin word fields, lowest bit last
    typedef struct packed {
        logic rdy;
        logic sda_out;
        logic drive_en;
    } pin_word_t;

    // predicted target state
    target_state_t    state;
    target_state_t    resume;
    logic [3:0]       nbits;
    logic [7:0]       shreg;
    logic [7:0]       ptr;
    logic             rw;
    logic             scl_q;
    logic             sda_q;
    logic             scl_d;
    logic             sda_d;
    logic             drv_en;
    logic             drv_val;
    logic             rdy;
    logic [CNT_W-1:0] ticks;
    logic [CNT_W-1:0] delay;
    logic [7:0]       regs [REG_COUNT];

    pin_word_t pin_queue [$];

    function automatic void reset_target();
        state   = ST_WAIT_IDLE;
        resume  = ST_ADDRESS;
        nbits   = '0;
        shreg   = '0;
        ptr     = '0;
        rw      = 1'b0;
        scl_q   = 1'b1;
        sda_q   = 1'b1;
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        drv_en  = 1'b0;
        drv_val = 1'b0;
        rdy     = 1'b0;
        ticks   = '0;
        delay   = DELAY_RESET;
        for (int i = 0; i < REG_COUNT; i++)
            regs[i] = 8'h00;
        // identity bytes
        regs[8'h00] = 8'h03;
        regs[8'h1F] = 8'h05;
        regs[8'h7F] = 8'h01;
        regs[8'h80] = 8'h23;
        regs[8'h81] = 8'h45;
        regs[8'h82] = 8'h67;
        regs[8'h83] = 8'h89;
    endfunction

    function automatic void shift_bit();
        shreg = {shreg[6:0], sda_q};
        nbits = nbits + 4'd1;
    endfunction

    // one bus sample through the target, returns the pins after the step
    function automatic pin_word_t step_target(input logic [7:0] w);
        logic      rise;
        logic      fall;
        logic [7:0] p;
        pin_word_t r;
        if (w[1])
            scl_q = w[0];
        if (w[3])
            sda_q = w[2];
        rise = !scl_d && scl_q;
        fall = scl_d && !scl_q;

        case (state)
            ST_WAIT_IDLE:
            begin
                if (scl_q && sda_q)
                    state = ST_WAIT_START;
            end
            ST_WAIT_START:
            begin
                if (scl_q && !sda_q)
                    state = resume;
                else if (!scl_q)
                    state = ST_WAIT_IDLE;
            end
            ST_ADDRESS:
            begin
                if (rise)
                begin
                    shift_bit();
                    if (nbits == 4'd8)
                    begin
                        rw     = shreg[0];
                        shreg  = '0;
                        nbits  = '0;
                        resume = rw ? ST_SEND_BIT : ST_POINTER;
                        state  = ST_ACK_RISE;
                    end
                end
            end
            ST_ACK_RISE:
            begin
                if (rise)
                begin
                    drv_en  = 1'b1;
                    drv_val = 1'b0;
                    state   = ST_ACK_FALL;
                end
            end
            ST_ACK_FALL:
            begin
                if (fall)
                begin
                    drv_en  = 1'b0;
                    drv_val = 1'b1;
                    state   = resume;
                end
            end
            ST_POINTER:
            begin
                if (rise)
                begin
                    shift_bit();
                    if (nbits == 4'd8)
                    begin
                        p = shreg;
                        if (p == PTR_REMAP_FROM)
                            p = PTR_REMAP_TO;
                        if (p == PTR_READY_CLEAR)
                        begin
                            rdy   = 1'b0;
                            ticks = '0;
                        end
                        ptr    = p;
                        shreg  = '0;
                        nbits  = '0;
                        resume = ST_FIRST_RISE;
                        state  = ST_ACK_RISE;
                    end
                end
            end
            ST_FIRST_RISE:
            begin
                if (rise)
                    state = ST_FIRST_LOW;
            end
            ST_FIRST_LOW:
            begin
                // clock low takes the first data bit, a falling data line is a repeated start
                if (!scl_q)
                begin
                    shreg = shreg | {7'b0, sda_d};
                    nbits = 4'd1;
                    state = ST_DATA_IN;
                end
                else if (!sda_q && sda_d)
                begin
                    resume = ST_ADDRESS;
                    state  = ST_WAIT_START;
                end
            end
            ST_DATA_IN:
            begin
                if (rise)
                begin
                    shift_bit();
                    if (nbits == 4'd8)
                    begin
                        regs[ptr] = shreg;
                        shreg     = '0;
                        nbits     = '0;
                        resume    = ST_STOP_RISE;
                        state     = ST_ACK_RISE;
                    end
                end
            end
            ST_STOP_RISE:
            begin
                if (rise && !sda_q)
                    state = ST_STOP_HIGH;
            end
            ST_STOP_HIGH:
            begin
                if (scl_q && sda_q)
                begin
                    resume = ST_ADDRESS;
                    state  = ST_WAIT_IDLE;
                end
            end
            ST_SEND_BIT:
            begin
                if (rise)
                begin
                    drv_en  = 1'b1;
                    drv_val = regs[ptr][3'd7 - nbits[2:0]];
                    nbits   = nbits + 4'd1;
                    if (nbits == 4'd8)
                    begin
                        shreg = '0;
                        nbits = '0;
                        state = ST_SEND_END;
                    end
                end
            end
            ST_SEND_END:
            begin
                if (fall)
                begin
                    drv_en  = 1'b0;
                    drv_val = 1'b1;
                    state   = ST_HOST_ACK;
                end
            end
            ST_HOST_ACK:
            begin
                if (rise)
                begin
                    if (sda_q)
                        state = ST_HOST_NACK_FALL;
                    else
                    begin
                        ptr   = ptr + 8'd1;
                        state = ST_HOST_ACK_FALL;
                    end
                end
            end
            ST_HOST_NACK_FALL:
            begin
                if (fall)
                begin
                    resume = ST_ADDRESS;
                    state  = ST_STOP_RISE;
                end
            end
            ST_HOST_ACK_FALL:
            begin
                if (fall)
                    state = ST_SEND_BIT;
            end
            default:
            begin
                state = ST_WAIT_IDLE;
            end
        endcase

        scl_d = scl_q;
        sda_d = sda_q;

        // saturating data-ready counter
        if (ticks != CNT_MAX)
            ticks = ticks + 1'b1;
        if (ticks == delay)
            rdy = 1'b1;

        r.drive_en = drv_en;
        r.sda_out  = drv_en & drv_val;
        r.rdy      = rdy;
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // watch config port, input words and result words
    always @(posedge clk or negedge rst_n)
    begin
        pin_word_t exp_w;
        pin_word_t got_w;
        if (!rst_n)
        begin
            reset_target();
            pin_queue.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == DELAY_ADDR)
            begin
                if (pwrite)
                    delay = pwdata[CNT_W-1:0];
                else if (prdata !== {{(32-CNT_W){1'b0}}, delay})
                begin
                    $display("%0t: delay readback mismatch, expected %0d, actual %0d",
                             $time, delay, prdata);
                    errors++;
                end
            end

            if (s_tvalid && s_tready)
                pin_queue.push_back(step_target(s_tdata));

            if (m_tvalid && m_tready)
            begin
                got_w = pin_word_t'(m_tdata[2:0]);
                if (pin_queue.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %b",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    exp_w = pin_queue.pop_front();
                    errors += field_diff("sda_drive_enable", exp_w.drive_en, got_w.drive_en);
                    errors += field_diff("sda_out", exp_w.sda_out, got_w.sda_out);
                    errors += field_diff("data_ready", exp_w.rdy, got_w.rdy);
                end
            end

            pending = pin_queue.size();
        end
    end

endmodule

[dv/tb_i2c_target_register_file.sv]
`timescale 1ns / 1ps

module tb_i2c_target_register_file;
    import i2ctrf_pkg::*;

    localparam int         RANDOM_WORDS     = 300;
    localparam int         PHASES           = 5;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // scl_level, scl_update, sda_level, sda_update
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // sda_drive_enable, sda_out, data_ready
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          check_errors;
    int          words_pending;

    // stimulus knobs and bus level tracking
    logic        scl_now;
    logic        sda_now;
    bit          quiet;
    int          send_gap_pct;
    int          stall_pct;
    int          words_sent;

    logic [7:0]  special_ptrs [9] = '{8'h00, 8'h1F, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83,
                                      8'hFE, 8'hFF};

    i2c_target_register_file dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    i2c_target_register_file_checker #(.DELAY_ADDR(ADDR_READY_DELAY)) u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .errors   (check_errors),
        .pending  (words_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // one word onto the input stream, returns at the falling edge after acceptance
    task automatic push_sample(input logic [7:0] w);
        if (!quiet && $urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // bus levels for one tick, an unchanged line may skip its update with a junk level
    task automatic bus_tick(input logic scl, input logic sda);
        logic cu;
        logic cl;
        logic su;
        logic sl;
        cu = (scl != scl_now) || ($urandom_range(0, 3) != 0);
        cl = cu ? scl : 1'($urandom_range(0, 1));
        su = (sda != sda_now) || ($urandom_range(0, 3) != 0);
        sl = su ? sda : 1'($urandom_range(0, 1));
        scl_now = scl;
        sda_now = sda;
        push_sample({4'b0, su, sl, cu, cl});
    endtask

    task automatic noise_sample();
        logic [7:0] w;
        w = 8'($urandom_range(0, 15));
        if (w[1])
            scl_now = w[0];
        if (w[3])
            sda_now = w[2];
        push_sample(w);
    endtask

    task automatic send_bit(input logic b);
        bus_tick(1'b0, b);
        bus_tick(1'b1, b);
    endtask

    task automatic send_byte(input logic [7:0] v);
        for (int i = 7; i >= 0; i--)
            send_bit(v[i]);
    endtask

    // start or repeated start
    task automatic bus_start();
        bus_tick(1'b0, 1'b1);
        bus_tick(1'b1, 1'b1);
        bus_tick(1'b1, 1'b1);
        bus_tick(1'b1, 1'b0);
        bus_tick(1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        bus_tick(1'b0, 1'b0);
        bus_tick(1'b1, 1'b0);
        bus_tick(1'b1, 1'b1);
    endtask

    // address byte with random target address, then the ack clock
    task automatic send_address(input logic rw);
        send_byte({7'($urandom_range(0, 127)), rw});
        send_bit(1'b0);
    endtask

    // a byte and an ack bit clocked with the data line released, then a stop
    task automatic bus_clear();
        repeat (9) send_bit(1'b1);
        bus_stop();
    endtask

    task automatic write_register(input logic [7:0] ptr, input logic [7:0] data);
        bus_start();
        send_address(1'b0);
        send_byte(ptr);
        send_bit(1'b0);
        send_byte(data);
        send_bit(1'b0);
        bus_stop();
    endtask

    // bytes out from the current pointer, master acks all but the last
    task automatic read_bytes(input int n);
        send_address(1'b1);
        for (int k = 0; k < n; k++)
        begin
            send_byte(8'($urandom_range(0, 255)));
            send_bit(k == n - 1);
        end
        bus_stop();
    endtask

    task automatic read_register(input logic [7:0] ptr, input int n);
        bus_start();
        send_address(1'b0);
        send_byte(ptr);
        send_bit(1'b0);
        bus_start();
        read_bytes(n);
    endtask

    function automatic logic [7:0] pick_pointer();
        if ($urandom_range(0, 1))
            return special_ptrs[$urandom_range(0, 8)];
        return 8'($urandom_range(0, 255));
    endfunction

    // wait until every result is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_ready_delay(input logic [CNT_W-1:0] ticks);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_READY_DELAY;
        pwdata  <= ($urandom() & ~32'(CNT_MAX)) | 32'(ticks);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_transaction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            write_register(pick_pointer(), 8'($urandom_range(0, 255)));
        else if (r < 62)
            read_register(pick_pointer(), $urandom_range(1, 4));
        else if (r < 77)
        begin
            bus_start();
            read_bytes($urandom_range(1, 3));
        end
        else if (r < 90)
        begin
            // stop after a random number of bits following the address
            bus_start();
            send_address(1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 12)) send_bit(1'($urandom_range(0, 1)));
            bus_stop();
            bus_clear();
        end
        else
        begin
            repeat ($urandom_range(1, 8)) noise_sample();
            bus_clear();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic [CNT_W-1:0] phase_delay [PHASES];
        int               phase_end;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        scl_now       = 1'b1;
        sda_now       = 1'b1;
        quiet         = 1'b0;
        send_gap_pct  = 10;
        stall_pct     = 10;
        words_sent    = 0;
        phase_delay   = '{CNT_MAX, DELAY_RESET, CNT_W'($urandom_range(2, 300)), 18'd1,
                          CNT_W'($urandom_range(20, 150))};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: shortest delay, ready clear, pointer remap, pointer wrap
        set_ready_delay(18'd1);
        write_register(PTR_READY_CLEAR, 8'hA5);
        write_register(PTR_REMAP_FROM, 8'h5A);
        read_register(PTR_REMAP_FROM, 2);
        read_register(8'hFF, 2);
        read_register(8'h1F, 1);
        bus_start();
        read_bytes(1);
        drain();

        // random phases, each with its own delay and idling mix
        words_sent = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_ready_delay(phase_delay[ph]);
            quiet        = (ph == PHASES - 1);
            send_gap_pct = $urandom_range(0, 2) * 8;
            stall_pct    = $urandom_range(0, 2) * 8;
            phase_end    = (ph + 1) * RANDOM_WORDS / PHASES;
            while (words_sent < phase_end)
                random_transaction();
            drain();
        end

        repeat (10) @(negedge clk);
        if (check_errors == 0 && words_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[i2c_target_register_file.f]
hw/rtl/i2ctrf_pkg.sv
hw/rtl/i2ctrf_regstore.sv
hw/rtl/i2c_target_register_file.sv
dv/i2c_target_register_file_checker.sv
dv/tb_i2c_target_register_file.sv
